[rtl/gtm_pkg.sv]
// Shared constants for the grid tile mixing block: action codes, tile operation
// codes, configuration register indexes and the mixing key.
// No dependencies; used by the top level and by the testbench.
package gtm_pkg;

    localparam int GRID_SIDE_DEFAULT = 8;

    localparam logic [63:0] MIX_KEY = 64'h9E37_79B9_7F4A_7C15;

    // Action carried in the input item's user field.
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_RUN  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Tile operation codes; the two remaining codes leave the value alone.
    localparam logic [2:0] OP_ADD_LEFT  = 3'd0;
    localparam logic [2:0] OP_SUB_RIGHT = 3'd1;
    localparam logic [2:0] OP_XOR_UP    = 3'd2;
    localparam logic [2:0] OP_ROTL_DOWN = 3'd3;
    localparam logic [2:0] OP_ROTR_UP   = 3'd4;
    localparam logic [2:0] OP_INVERT    = 3'd5;

    // Configuration register indexes.
    localparam int          CFG_ADDR_W        = 8;
    localparam int          CFG_DATA_W        = 16;
    localparam logic [7:0]  CFG_START_X       = 8'd0;
    localparam logic [7:0]  CFG_START_Y       = 8'd1;
    localparam logic [7:0]  CFG_ROUND_COUNT   = 8'd2;
    localparam logic [7:0]  CFG_OUTPUT_BITS   = 8'd3;

    localparam logic [15:0] ROUND_COUNT_RESET = 16'd1;
    localparam logic [12:0] OUTPUT_BITS_RESET = 13'd64;

endpackage

[rtl/gtm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the tile value and tile code stores; no package dependency.
module gtm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/grid_tile_mixing_rounds.sv]
// Top level of the grid tile mixing block: tile stores, mixing sequencer,
// configuration registers and the result register.
// Depends on gtm_pkg and gtm_ram.
//
//  Channel  | Direction | Handshake            | Contents
//  ---------+-----------+----------------------+-----------------------------------
//  s_       | in        | s_tvalid / s_tready  | tuser: action; tdata: tile item
//  m_       | out       | m_tvalid / m_tready  | tuser: run_done; tdata: tile read
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_addr index, cfg_data value
//
// A load item writes the tile stores from idle; a read item moves to ST_READ,
// where the registered RAM read returns. A run item visits every tile each
// round: the single value RAM read port is used twice per tile (own value,
// then neighbour), the shared tile ALU runs and the result is written back.
// Reset is synchronous and active low; it clears the control state and the
// configuration registers, not the tile stores. Input is held off while a run
// or read is under way, or while an untaken result holds the output register.
module grid_tile_mixing_rounds #(
    parameter int GRID_SIDE = gtm_pkg::GRID_SIDE_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] tile_row, [5:3] tile_col, [69:6] load_value, [72:70] load_op,
    // [79:73] zero
    input  logic [79:0]                     s_tdata,
    // [1:0] action
    input  logic [1:0]                      s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] tile_value, [66:64] tile_op, [71:67] zero
    output logic [71:0]                     m_tdata,
    // [0] run_done
    output logic [0:0]                      m_tuser,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gtm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [gtm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int NTILES = GRID_SIDE * GRID_SIDE;
    localparam int IDX_W  = $clog2(GRID_SIDE);
    localparam int ADDR_W = $clog2(NTILES);

    localparam logic [IDX_W:0]    SIDE_W = (IDX_W + 1)'(GRID_SIDE);
    localparam logic [IDX_W-1:0]  LAST_I = IDX_W'(GRID_SIDE - 1);
    localparam logic [ADDR_W-1:0] SIDE_A = ADDR_W'(GRID_SIDE);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(NTILES - 1);
    localparam logic [6:0]        SIDE_7 = 7'(GRID_SIDE);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_FETCH = 6'b000100,
        ST_NEIGH = 6'b001000,
        ST_ALU   = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    // Start offsets are below eight, so a few conditional subtractions reduce
    // them modulo the grid side.
    function automatic logic [IDX_W-1:0] side_mod(input logic [2:0] v);
        logic [6:0] t;
        t = {4'b0, v};
        for (int i = 0; i < 4; i++) begin
            if (t >= SIDE_7) begin
                t = t - SIDE_7;
            end
        end
        return t[IDX_W-1:0];
    endfunction

    // Input fields.
    logic [1:0]  in_action;
    logic [2:0]  in_row;
    logic [2:0]  in_col;
    logic [63:0] in_value;
    logic [2:0]  in_op;

    assign in_action = s_tuser;
    assign in_row    = s_tdata[2:0];
    assign in_col    = s_tdata[5:3];
    assign in_value  = s_tdata[69:6];
    assign in_op     = s_tdata[72:70];

    // Control and configuration registers.
    state_t            state_reg, state_next;
    logic [2:0]        start_x_reg, start_y_reg;
    logic [15:0]       round_count_reg;
    logic [12:0]       output_bits_reg;
    logic              m_tvalid_reg, m_tvalid_next;

    // Sequencer and datapath registers.
    logic [IDX_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic [IDX_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [ADDR_W-1:0] lin_reg, lin_next;
    logic [15:0]       rounds_left_reg, rounds_left_next;
    logic [63:0]       key_reg, key_next;
    logic [63:0]       own_reg, own_next;
    logic [2:0]        op_reg, op_next;
    logic [63:0]       keyidx_reg, keyidx_next;
    logic [63:0]       mix_reg, mix_next;
    logic              inside_reg, inside_next;
    logic [63:0]       m_value_reg, m_value_next;
    logic [2:0]        m_op_reg, m_op_next;
    logic              m_done_reg, m_done_next;

    // RAM ports.
    logic              v_we, o_we;
    logic [ADDR_W-1:0] v_waddr, v_raddr, o_raddr;
    logic [63:0]       v_wdata, v_rdata;
    logic [2:0]        o_rdata;

    gtm_ram #(
        .WIDTH (64),
        .DEPTH (NTILES)
    ) u_value_ram (
        .clk   (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    gtm_ram #(
        .WIDTH (3),
        .DEPTH (NTILES)
    ) u_op_ram (
        .clk   (aclk),
        .we    (o_we),
        .waddr (v_waddr),
        .wdata (in_op),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'b0, m_op_reg, m_value_reg};
    assign m_tuser   = m_done_reg;

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // Tile address of a load or read item, and whether it lies in the grid.
    logic [12:0]       tile_lin13;
    logic [ADDR_W-1:0] tile_addr;
    logic              tile_inside;

    assign tile_lin13  = 13'(in_row) * 13'(GRID_SIDE) + 13'(in_col);
    assign tile_addr   = tile_lin13[ADDR_W-1:0];
    assign tile_inside = ({4'b0, in_row} < SIDE_7) && ({4'b0, in_col} < SIDE_7);

    // Number of rounds for a run: at least one per 64-bit output block.
    logic [12:0] bits_eff;
    logic [11:0] blocks_sum;
    logic [7:0]  blocks;
    logic [15:0] rounds_total;

    assign bits_eff     = (output_bits_reg < 13'd64) ? 13'd64 : output_bits_reg;
    assign blocks_sum   = {1'b0, bits_eff[12:2]} + 12'd15;
    assign blocks       = blocks_sum[11:4];
    assign rounds_total = (round_count_reg < {8'b0, blocks}) ? {8'b0, blocks}
                                                             : round_count_reg;

    // Position of the code tile that drives the current tile.
    logic [IDX_W:0]    orow_sum, ocol_sum;
    logic [IDX_W-1:0]  orow, ocol;
    logic [ADDR_W-1:0] off_addr;

    assign orow_sum = {1'b0, px_reg} + {1'b0, row_reg};
    assign ocol_sum = {1'b0, py_reg} + {1'b0, col_reg};
    assign orow     = (orow_sum >= SIDE_W) ? IDX_W'(orow_sum - SIDE_W) : orow_sum[IDX_W-1:0];
    assign ocol     = (ocol_sum >= SIDE_W) ? IDX_W'(ocol_sum - SIDE_W) : ocol_sum[IDX_W-1:0];
    assign off_addr = ADDR_W'(orow) * SIDE_A + ADDR_W'(ocol);

    // Neighbour address chosen by the tile's operation code.
    logic [ADDR_W-1:0] neigh_addr;

    always_comb begin
        case (o_rdata)
            gtm_pkg::OP_ADD_LEFT:  neigh_addr = lin_reg - 1'b1;
            gtm_pkg::OP_SUB_RIGHT: neigh_addr = lin_reg + 1'b1;
            gtm_pkg::OP_XOR_UP:    neigh_addr = lin_reg - SIDE_A;
            gtm_pkg::OP_ROTR_UP:   neigh_addr = lin_reg - SIDE_A;
            gtm_pkg::OP_ROTL_DOWN: neigh_addr = lin_reg + SIDE_A;
            default:               neigh_addr = lin_reg;
        endcase
    end

    // Shared tile ALU. On a grid edge the missing neighbour reads as one.
    logic [63:0] alu_out;
    logic        first_col, last_col, first_row, last_row;

    assign first_col = (col_reg == '0);
    assign last_col  = (col_reg == LAST_I);
    assign first_row = (row_reg == '0);
    assign last_row  = (row_reg == LAST_I);

    always_comb begin
        case (op_reg)
            gtm_pkg::OP_ADD_LEFT:
                alu_out = own_reg + (first_col ? 64'd1 : v_rdata);
            gtm_pkg::OP_SUB_RIGHT:
                alu_out = own_reg - (last_col ? 64'd1 : v_rdata);
            gtm_pkg::OP_XOR_UP:
                alu_out = own_reg ^ (first_row ? 64'd1 : v_rdata);
            gtm_pkg::OP_ROTL_DOWN:
                alu_out = {own_reg[50:0], own_reg[63:51]} ^ (last_row ? 64'd1 : v_rdata);
            gtm_pkg::OP_ROTR_UP:
                alu_out = {own_reg[6:0], own_reg[63:7]} + (first_row ? 64'd1 : v_rdata);
            gtm_pkg::OP_INVERT:
                alu_out = ~own_reg;
            default:
                alu_out = own_reg;
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        lin_next         = lin_reg;
        rounds_left_next = rounds_left_reg;
        key_next         = key_reg;
        own_next         = own_reg;
        op_next          = op_reg;
        keyidx_next      = keyidx_reg;
        mix_next         = mix_reg;
        inside_next      = inside_reg;
        m_value_next     = m_value_reg;
        m_op_next        = m_op_reg;
        m_done_next      = m_done_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;

        v_we    = 1'b0;
        o_we    = 1'b0;
        v_waddr = tile_addr;
        v_wdata = in_value;
        v_raddr = tile_addr;
        o_raddr = tile_addr;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (in_action)
                        gtm_pkg::ACT_LOAD: begin
                            // Loads outside the grid are dropped.
                            v_we          = tile_inside;
                            o_we          = tile_inside;
                            m_tvalid_next = 1'b1;
                            m_value_next  = '0;
                            m_op_next     = '0;
                            m_done_next   = 1'b0;
                        end
                        gtm_pkg::ACT_RUN: begin
                            px_next          = side_mod(start_x_reg);
                            py_next          = side_mod(start_y_reg);
                            row_next         = '0;
                            col_next         = '0;
                            lin_next         = '0;
                            rounds_left_next = rounds_total;
                            key_next         = gtm_pkg::MIX_KEY;
                            state_next       = ST_FETCH;
                        end
                        gtm_pkg::ACT_READ: begin
                            inside_next = tile_inside;
                            state_next  = ST_READ;
                        end
                        default: begin
                            m_tvalid_next = 1'b1;
                            m_value_next  = '0;
                            m_op_next     = '0;
                            m_done_next   = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                m_tvalid_next = 1'b1;
                m_value_next  = inside_reg ? v_rdata : '0;
                m_op_next     = inside_reg ? o_rdata : '0;
                m_done_next   = 1'b0;
                state_next    = ST_IDLE;
            end
            ST_FETCH: begin
                v_raddr    = lin_reg;
                o_raddr    = off_addr;
                state_next = ST_NEIGH;
            end
            ST_NEIGH: begin
                own_next    = v_rdata;
                op_next     = o_rdata;
                keyidx_next = key_reg + 64'(lin_reg);
                v_raddr     = neigh_addr;
                state_next  = ST_ALU;
            end
            ST_ALU: begin
                mix_next   = alu_out;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                v_we     = 1'b1;
                v_waddr  = lin_reg;
                v_wdata  = mix_reg + keyidx_reg;
                lin_next = lin_reg + 1'b1;
                if (col_reg == LAST_I) begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
                state_next = ST_FETCH;
                if (lin_reg == LAST_A) begin
                    // End of a round: move the code window, bump the key.
                    lin_next         = '0;
                    row_next         = '0;
                    col_next         = '0;
                    key_next         = key_reg + gtm_pkg::MIX_KEY;
                    rounds_left_next = rounds_left_reg - 1'b1;
                    if (px_reg == LAST_I) begin
                        px_next = '0;
                        py_next = (py_reg == LAST_I) ? '0 : py_reg + 1'b1;
                    end else begin
                        px_next = px_reg + 1'b1;
                    end
                    if (rounds_left_reg == 16'd1) begin
                        m_tvalid_next = 1'b1;
                        m_value_next  = '0;
                        m_op_next     = '0;
                        m_done_next   = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            round_count_reg <= gtm_pkg::ROUND_COUNT_RESET;
            output_bits_reg <= gtm_pkg::OUTPUT_BITS_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    gtm_pkg::CFG_START_X:     start_x_reg     <= cfg_data[2:0];
                    gtm_pkg::CFG_START_Y:     start_y_reg     <= cfg_data[2:0];
                    gtm_pkg::CFG_ROUND_COUNT: round_count_reg <= cfg_data;
                    gtm_pkg::CFG_OUTPUT_BITS: output_bits_reg <= cfg_data[12:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath and payload registers need no reset.
    always_ff @(posedge aclk) begin
        px_reg          <= px_next;
        py_reg          <= py_next;
        row_reg         <= row_next;
        col_reg         <= col_next;
        lin_reg         <= lin_next;
        rounds_left_reg <= rounds_left_next;
        key_reg         <= key_next;
        own_reg         <= own_next;
        op_reg          <= op_next;
        keyidx_reg      <= keyidx_next;
        mix_reg         <= mix_next;
        inside_reg      <= inside_next;
        m_value_reg     <= m_value_next;
        m_op_reg        <= m_op_next;
        m_done_reg      <= m_done_next;
    end

endmodule

[verif/testbench.sv]
// Self-checking testbench for grid_tile_mixing_rounds: loads, reads and mixing runs
// are predicted by a tile grid scoreboard and compared with the result stream.
// Depends on gtm_pkg and the grid_tile_mixing_rounds RTL.
`timescale 1ns / 1ps

// Tracks the tile grid, the configuration and the results still owed by the block.
class tile_mix_scoreboard;

    localparam int SIDE = gtm_pkg::GRID_SIDE_DEFAULT;

    typedef struct {
        bit [63:0] value;
        bit [2:0]  code;
        bit        done;
    } tile_result_t;

    bit [63:0]    tile_val [SIDE*SIDE];
    bit [2:0]     tile_code [SIDE*SIDE];
    bit [2:0]     start_x;
    bit [2:0]     start_y;
    bit [15:0]    round_count;
    bit [12:0]    output_bits;
    tile_result_t owed_results [$];
    int           errors;

    function new();
        start_x     = '0;
        start_y     = '0;
        round_count = gtm_pkg::ROUND_COUNT_RESET;
        output_bits = gtm_pkg::OUTPUT_BITS_RESET;
        errors      = 0;
    endfunction

    function void write_reg(logic [gtm_pkg::CFG_ADDR_W-1:0] addr,
                            logic [gtm_pkg::CFG_DATA_W-1:0] data);
        case (addr)
            gtm_pkg::CFG_START_X:     start_x     = data[2:0];
            gtm_pkg::CFG_START_Y:     start_y     = data[2:0];
            gtm_pkg::CFG_ROUND_COUNT: round_count = data;
            gtm_pkg::CFG_OUTPUT_BITS: output_bits = data[12:0];
            default: ;
        endcase
    endfunction

    // Updates one tile in place; neighbours already visited this round are
    // seen with their new values.
    function void mix_tile(bit [2:0] code, int r, int c, bit [63:0] key);
        int        idx;
        bit [63:0] v;
        idx = r * SIDE + c;
        v   = tile_val[idx];
        case (code)
            gtm_pkg::OP_ADD_LEFT:
                v = v + ((c == 0) ? 64'd1 : tile_val[idx-1]);
            gtm_pkg::OP_SUB_RIGHT:
                v = v - ((c == SIDE-1) ? 64'd1 : tile_val[idx+1]);
            gtm_pkg::OP_XOR_UP:
                v = v ^ ((r == 0) ? 64'd1 : tile_val[idx-SIDE]);
            gtm_pkg::OP_ROTL_DOWN:
                v = {v[50:0], v[63:51]} ^ ((r == SIDE-1) ? 64'd1 : tile_val[idx+SIDE]);
            gtm_pkg::OP_ROTR_UP:
                v = {v[6:0], v[63:7]} + ((r == 0) ? 64'd1 : tile_val[idx-SIDE]);
            gtm_pkg::OP_INVERT:
                v = ~v;
            default: ;
        endcase
        tile_val[idx] = v + key + 64'(idx);
    endfunction

    function void mix_grid();
        bit [63:0] eff_bits;
        bit [63:0] blocks;
        bit [63:0] rounds;
        bit [63:0] key;
        int        px;
        int        py;
        eff_bits = (output_bits < 64) ? 64'd64 : 64'(output_bits);
        blocks   = (eff_bits / 4 + 15) / 16;
        rounds   = (64'(round_count) < blocks) ? blocks : 64'(round_count);
        px       = start_x % SIDE;
        py       = start_y % SIDE;
        for (bit [63:0] k = 0; k < rounds; k++) begin
            key = gtm_pkg::MIX_KEY * (k + 64'd1);
            for (int r = 0; r < SIDE; r++) begin
                for (int c = 0; c < SIDE; c++) begin
                    mix_tile(tile_code[((px + r) % SIDE) * SIDE + (py + c) % SIDE], r, c, key);
                end
            end
            px++;
            if (px == SIDE) begin
                px = 0;
                py = (py + 1) % SIDE;
            end
        end
    endfunction

    // Called for every item the block accepts; queues the result it owes.
    function void note_item(bit [1:0] action, bit [2:0] row, bit [2:0] col,
                            bit [63:0] value, bit [2:0] code);
        tile_result_t res;
        int           idx;
        res = '{value: '0, code: '0, done: 1'b0};
        idx = row * SIDE + col;
        case (action)
            gtm_pkg::ACT_LOAD: begin
                tile_val[idx]  = value;
                tile_code[idx] = code;
            end
            gtm_pkg::ACT_RUN: begin
                mix_grid();
                res.done = 1'b1;
            end
            gtm_pkg::ACT_READ: begin
                res.value = tile_val[idx];
                res.code  = tile_code[idx];
            end
            default: ;
        endcase
        owed_results.push_back(res);
    endfunction

    function void check_result(logic [71:0] tdata, logic [0:0] tuser);
        tile_result_t want;
        if (owed_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: value %h code %0d done %0b",
                     $time, tdata[63:0], tdata[66:64], tuser[0]);
            return;
        end
        want = owed_results.pop_front();
        if (tdata[63:0] !== want.value) begin
            errors++;
            $display("%0t: tile_value mismatch: expected %h actual %h",
                     $time, want.value, tdata[63:0]);
        end
        if (tdata[66:64] !== want.code) begin
            errors++;
            $display("%0t: tile_op mismatch: expected %0d actual %0d",
                     $time, want.code, tdata[66:64]);
        end
        if (tuser[0] !== want.done) begin
            errors++;
            $display("%0t: run_done mismatch: expected %0b actual %0b",
                     $time, want.done, tuser[0]);
        end
    endfunction

    function int outstanding();
        return owed_results.size();
    endfunction

endclass

module testbench;

    localparam int SIDE = gtm_pkg::GRID_SIDE_DEFAULT;

    // The package names no code for the fourth action or for the two
    // operation codes that leave a tile alone.
    localparam logic [1:0] ACT_NONE  = 2'd3;
    localparam logic [2:0] OP_KEEP_A = 3'd6;
    localparam logic [2:0] OP_KEEP_B = 3'd7;

    // A 64-round run accepts nothing while it lasts, so the watchdog limit is
    // set well above the length of such a run.
    localparam int QUIET_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_TICKS = 10;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [gtm_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [gtm_pkg::CFG_DATA_W-1:0] cfg_data;

    tile_mix_scoreboard board;

    // Idle rates in percent, changed by the main sequence between phases.
    int send_gap_pct = 0;
    int stall_pct    = 0;
    bit hold_req     = 1'b0;

    // Settings per phase: both start offsets, requested rounds, output bits,
    // and the share of run items. The phase with 65535 requested rounds sends
    // no run, since such a run would trip the watchdog.
    int ph_start_x [PHASES] = '{0, 7, 3, 1, 6, 2, 4, 7};
    int ph_start_y [PHASES] = '{0, 7, 5, 6, 2, 7, 1, 0};
    int ph_rounds  [PHASES] = '{1, 0, 3, 0, 65535, 9, 2, 17};
    int ph_bits    [PHASES] = '{64, 0, 68, 4096, 0, 256, 127, 1000};
    int ph_run_pct [PHASES] = '{10, 10, 10, 1, 0, 8, 10, 3};

    grid_tile_mixing_rounds #(
        .GRID_SIDE (SIDE)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Offers one item, with random idle cycles ahead of it, and returns at the
    // edge where it is accepted. The valid stays high so that a following item
    // can go out back to back; only a gap or the end of a burst lowers it.
    task automatic send_item(input logic [1:0] action, input logic [2:0] row,
                             input logic [2:0] col, input logic [63:0] value,
                             input logic [2:0] code);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {7'd0, code, value, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_item(action, row, col, value, code);
    endtask

    // Ends a burst and waits until every owed result has come back, then lets
    // the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [gtm_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [gtm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(addr, data);
    endtask

    // Writes all four registers back to back; only called while the block is idle.
    task automatic configure(input int sx, input int sy, input int rounds, input int bits);
        write_reg(gtm_pkg::CFG_START_X, gtm_pkg::CFG_DATA_W'(sx));
        write_reg(gtm_pkg::CFG_START_Y, gtm_pkg::CFG_DATA_W'(sy));
        write_reg(gtm_pkg::CFG_ROUND_COUNT, gtm_pkg::CFG_DATA_W'(rounds));
        write_reg(gtm_pkg::CFG_OUTPUT_BITS, gtm_pkg::CFG_DATA_W'(bits));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Loads every tile so that no run and no read ever touches an unwritten
    // entry. Codes step through all eight values from a random starting point.
    task automatic fill_grid();
        int spin;
        spin = $urandom_range(7);
        for (int i = 0; i < SIDE * SIDE; i++) begin
            send_item(gtm_pkg::ACT_LOAD, 3'(i / SIDE), 3'(i % SIDE), pick_value(),
                      3'(i + spin));
        end
    endtask

    // Random mix of loads, reads, runs and the unused action. Fields that an
    // action ignores are still random so that the block must disregard them.
    task automatic random_items(input int count, input int run_pct);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < run_pct) begin
                send_item(gtm_pkg::ACT_RUN, 3'($urandom), 3'($urandom),
                          {$urandom, $urandom}, 3'($urandom));
            end else if (pick < run_pct + 4) begin
                send_item(ACT_NONE, 3'($urandom), 3'($urandom), {$urandom, $urandom},
                          3'($urandom));
            end else if (pick < run_pct + 50) begin
                send_item(gtm_pkg::ACT_LOAD, 3'($urandom), 3'($urandom), pick_value(),
                          3'($urandom));
            end else begin
                send_item(gtm_pkg::ACT_READ, 3'($urandom), 3'($urandom),
                          {$urandom, $urandom}, 3'($urandom));
            end
        end
    endtask

    // Result side: checks every accepted item, stalls at random, and on request
    // holds off for a long stretch so that the block backs up and stalls its input.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                board.check_result(m_tdata, m_tuser);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        board     = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        configure(0, 0, 1, 64);

        // Directed part: corner tiles with extreme values and both codes that
        // leave a tile alone, read back, then the unused action with every
        // field set, which must change nothing and return zeros.
        send_item(gtm_pkg::ACT_LOAD, 3'd0, 3'd0, 64'd0, gtm_pkg::OP_ADD_LEFT);
        send_item(gtm_pkg::ACT_LOAD, 3'd7, 3'd7, '1, OP_KEEP_B);
        send_item(gtm_pkg::ACT_LOAD, 3'd0, 3'd7, 64'h8000_0000_0000_0001,
                  gtm_pkg::OP_ROTL_DOWN);
        send_item(gtm_pkg::ACT_LOAD, 3'd7, 3'd0, 64'h5555_5555_AAAA_AAAA, OP_KEEP_A);
        send_item(gtm_pkg::ACT_READ, 3'd0, 3'd0, '0, '0);
        send_item(gtm_pkg::ACT_READ, 3'd7, 3'd7, '1, '1);
        send_item(gtm_pkg::ACT_READ, 3'd0, 3'd7, '0, '0);
        send_item(gtm_pkg::ACT_READ, 3'd7, 3'd0, '0, '0);
        send_item(ACT_NONE, 3'd7, 3'd7, '1, '1);
        send_item(gtm_pkg::ACT_READ, 3'd7, 3'd7, '0, '0);

        // Full grid, then runs that exercise every code at the grid edges,
        // where the neighbour is replaced by one.
        fill_grid();
        send_item(gtm_pkg::ACT_RUN, '0, '0, '0, '0);
        send_item(gtm_pkg::ACT_READ, 3'd0, 3'd0, '0, '0);
        send_item(gtm_pkg::ACT_READ, 3'd7, 3'd7, '0, '0);
        send_item(gtm_pkg::ACT_RUN, '1, '1, '1, '1);
        send_item(gtm_pkg::ACT_READ, 3'd0, 3'd7, '0, '0);
        send_item(gtm_pkg::ACT_READ, 3'd7, 3'd0, '0, '0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            configure(ph_start_x[p], ph_start_y[p], ph_rounds[p], ph_bits[p]);
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 66; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 66; end
                default: begin send_gap_pct = 20; stall_pct = 20; end
            endcase
            if (p == 0) begin
                // Back-pressure: the result side holds off while items keep
                // coming, then the input side pauses until all results are in.
                random_items(80, ph_run_pct[p]);
                hold_req = 1'b1;
                random_items(40, ph_run_pct[p]);
                drain();
                random_items(PHASE_ITEMS - 120, ph_run_pct[p]);
            end else begin
                random_items(PHASE_ITEMS, ph_run_pct[p]);
            end
            drain();
        end

        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/gtm_pkg.sv
rtl/gtm_ram.sv
rtl/grid_tile_mixing_rounds.sv
verif/testbench.sv
